// ===== src/kus_pkg.sv =====
// ----------------------------------------------------------------------------
// kus_pkg
// Shared field widths, operation and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kus_pkg;

  localparam int ACT_W  = 2;
  localparam int KEY_W  = 32;
  localparam int PAY_W  = 16;
  localparam int STS_W  = 2;
  localparam int FILL_W = 5;

  // Requested operation.
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_TOP    = 2'd2,
    ACT_SEARCH = 2'd3
  } kus_act_t;

  // Result status.
  typedef enum logic [STS_W-1:0] {
    STS_OK   = 2'd0,
    STS_DUP  = 2'd1,
    STS_MISS = 2'd2,
    STS_FULL = 2'd3
  } kus_sts_code_t;

  // How the datapath forms the result when the controller captures it.
  typedef enum logic [1:0] {
    RES_DATA = 2'd0,
    RES_MISS = 2'd1,
    RES_DUP  = 2'd2,
    RES_PUSH = 2'd3
  } kus_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_TOP_CAP,
    ST_POST
  } kus_state_t;

  typedef struct packed {
    logic     load;
    logic     scan;
    logic     capture;
    kus_res_t res_sel;
    logic     post;
  } kus_cmd_t;

  typedef struct packed {
    kus_act_t action;
    logic     empty;
    logic     hit;
    logic     exhausted;
    logic     out_busy;
  } kus_sts_t;

endpackage

`default_nettype wire

// ===== src/kus_if.sv =====
// ----------------------------------------------------------------------------
// kus_in_if / kus_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface kus_in_if;
  logic                     valid;
  logic                     ready;
  logic [kus_pkg::ACT_W-1:0] action;
  logic [kus_pkg::KEY_W-1:0] key;
  logic [kus_pkg::PAY_W-1:0] payload;

  modport source (output valid, output action, output key, output payload, input ready);
  modport sink   (input valid, input action, input key, input payload, output ready);
endinterface

interface kus_out_if;
  logic                      valid;
  logic                      ready;
  logic [kus_pkg::STS_W-1:0]  status;
  logic [kus_pkg::KEY_W-1:0]  out_key;
  logic [kus_pkg::PAY_W-1:0]  out_payload;
  logic                      is_empty;
  logic [kus_pkg::FILL_W-1:0] fill_count;

  modport source (output valid, output status, output out_key, output out_payload,
                  output is_empty, output fill_count, input ready);
  modport sink   (input valid, input status, input out_key, input out_payload,
                  input is_empty, input fill_count, output ready);
endinterface

`default_nettype wire

// ===== src/kus_ram.sv =====
// ----------------------------------------------------------------------------
// kus_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kus_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/kus_ctrl.sv =====
// ----------------------------------------------------------------------------
// kus_ctrl
// Controller: sequences one request at a time through dispatch, key scan or
// top read, result capture and hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kus_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire kus_pkg::kus_sts_t sts,
  output kus_pkg::kus_cmd_t      cmd
);

  kus_pkg::kus_state_t state_r, state_nxt;
  logic is_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kus_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign is_push = (sts.action == kus_pkg::ACT_PUSH);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = kus_pkg::RES_MISS;
    in_ready    = 1'b0;
    case (state_r)
      kus_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = kus_pkg::ST_DISPATCH;
        end
      end
      kus_pkg::ST_DISPATCH: begin
        if (sts.action == kus_pkg::ACT_POP || sts.action == kus_pkg::ACT_TOP) begin
          if (sts.empty) begin
            cmd.capture = 1'b1;
            cmd.res_sel = kus_pkg::RES_MISS;
            state_nxt   = kus_pkg::ST_POST;
          end else begin
            // The read port addresses the top slot whenever no scan runs.
            state_nxt = kus_pkg::ST_TOP_CAP;
          end
        end else begin
          cmd.scan  = 1'b1;
          state_nxt = kus_pkg::ST_SCAN;
        end
      end
      kus_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.capture = 1'b1;
          cmd.res_sel = is_push ? kus_pkg::RES_DUP : kus_pkg::RES_DATA;
          state_nxt   = kus_pkg::ST_POST;
        end else if (sts.exhausted) begin
          cmd.capture = 1'b1;
          cmd.res_sel = is_push ? kus_pkg::RES_PUSH : kus_pkg::RES_MISS;
          state_nxt   = kus_pkg::ST_POST;
        end
      end
      kus_pkg::ST_TOP_CAP: begin
        cmd.capture = 1'b1;
        cmd.res_sel = kus_pkg::RES_DATA;
        state_nxt   = kus_pkg::ST_POST;
      end
      kus_pkg::ST_POST: begin
        if (!sts.out_busy) begin
          cmd.post  = 1'b1;
          state_nxt = kus_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kus_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/kus_dp.sv =====
// ----------------------------------------------------------------------------
// kus_dp
// Datapath: request register, record RAM, scan counter, depth register,
// result register and the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module kus_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire kus_pkg::kus_cmd_t           cmd,
  output kus_pkg::kus_sts_t                sts,
  input  wire logic [kus_pkg::ACT_W-1:0]   in_action,
  input  wire logic [kus_pkg::KEY_W-1:0]   in_key,
  input  wire logic [kus_pkg::PAY_W-1:0]   in_payload,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [kus_pkg::STS_W-1:0]   out_status,
  output logic      [kus_pkg::KEY_W-1:0]   out_key,
  output logic      [kus_pkg::PAY_W-1:0]   out_payload,
  output logic                             out_is_empty,
  output logic      [kus_pkg::FILL_W-1:0]  out_fill_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int DW = $clog2(DEPTH + 1);
  localparam int RW = kus_pkg::KEY_W + kus_pkg::PAY_W;
  localparam logic [DW-1:0] DEPTH_C = DW'(DEPTH);

  kus_pkg::kus_act_t        act_r;
  logic [kus_pkg::KEY_W-1:0] key_r;
  logic [kus_pkg::PAY_W-1:0] pay_r;

  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] idx_r, idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [DW-1:0] top_addr;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;
  logic [kus_pkg::KEY_W-1:0] rd_key;
  logic [kus_pkg::PAY_W-1:0] rd_pay;

  kus_pkg::kus_sts_code_t    res_status_r, res_status_nxt;
  logic [kus_pkg::KEY_W-1:0] res_key_r, res_key_nxt;
  logic [kus_pkg::PAY_W-1:0] res_pay_r, res_pay_nxt;

  logic out_vld_r;
  logic [kus_pkg::STS_W-1:0]  out_status_r;
  logic [kus_pkg::KEY_W-1:0]  out_key_r;
  logic [kus_pkg::PAY_W-1:0]  out_pay_r;
  logic                       out_empty_r;
  logic [kus_pkg::FILL_W-1:0] out_fill_r;

  assign rd_key   = ram_rdata[RW-1:kus_pkg::PAY_W];
  assign rd_pay   = ram_rdata[kus_pkg::PAY_W-1:0];
  assign top_addr = depth_r - DW'(1);
  assign ram_raddr = cmd.scan ? idx_r[AW-1:0] : top_addr[AW-1:0];

  kus_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (depth_r[AW-1:0]),
    .wdata ({key_r, pay_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan counter: one read issued per cycle, compared in the cycle after.
  always_comb begin
    idx_nxt    = idx_r;
    rd_vld_nxt = 1'b0;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.scan && (idx_r < depth_r)) begin
      idx_nxt    = idx_r + DW'(1);
      rd_vld_nxt = 1'b1;
    end
  end

  always_comb begin
    depth_nxt      = depth_r;
    ram_we         = 1'b0;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_pay_nxt    = res_pay_r;
    if (cmd.capture) begin
      res_key_nxt    = '0;
      res_pay_nxt    = '0;
      res_status_nxt = kus_pkg::STS_OK;
      case (cmd.res_sel)
        kus_pkg::RES_DATA: begin
          res_key_nxt = rd_key;
          res_pay_nxt = rd_pay;
          if (act_r == kus_pkg::ACT_POP) begin
            depth_nxt = top_addr;
          end
        end
        kus_pkg::RES_MISS: res_status_nxt = kus_pkg::STS_MISS;
        kus_pkg::RES_DUP:  res_status_nxt = kus_pkg::STS_DUP;
        kus_pkg::RES_PUSH: begin
          if (depth_r >= DEPTH_C) begin
            res_status_nxt = kus_pkg::STS_FULL;
          end else begin
            ram_we    = 1'b1;
            depth_nxt = depth_r + DW'(1);
          end
        end
        default: res_status_nxt = kus_pkg::STS_MISS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      depth_r  <= depth_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (cmd.post) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_pay_r    <= res_pay_nxt;
    if (cmd.load) begin
      act_r <= kus_pkg::kus_act_t'(in_action);
      key_r <= in_key;
      pay_r <= in_payload;
    end
    if (cmd.post) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_pay_r    <= res_pay_r;
      out_empty_r  <= (depth_r == '0);
      out_fill_r   <= kus_pkg::FILL_W'(depth_r);
    end
  end

  assign sts.action    = act_r;
  assign sts.empty     = (depth_r == '0);
  assign sts.hit       = rd_vld_r && (rd_key == key_r);
  assign sts.exhausted = !rd_vld_r && (idx_r >= depth_r);
  assign sts.out_busy  = out_vld_r && !out_ready;

  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_key        = out_key_r;
  assign out_payload    = out_pay_r;
  assign out_is_empty   = out_empty_r;
  assign out_fill_count = out_fill_r;

endmodule

`default_nettype wire

// ===== src/keyed_unique_stack_core.sv =====
// ----------------------------------------------------------------------------
// keyed_unique_stack_core
// Bounded LIFO of keyed records with unique keys and search by key.
// ----------------------------------------------------------------------------
// The request channel (in_ch) carries an action (push, pop, top, search), a
// 32-bit key and a 16-bit payload handle. Each request gives exactly one
// transfer on the result channel (out_ch): status, returned key and payload
// (zero for pushes, misses and empty pops), empty flag and fill count.
// Requests are handled one at a time. Pop and top read the top slot and
// capture it as the result; on an empty stack they capture a miss instead.
// Push and search scan the stored keys from the bottom, one RAM read per
// cycle; a matching key (search hit or duplicate push) stops the scan early.
// Only after a hand-off does the controller go idle and take a new request.
// A new request is taken while an earlier result still waits in the output
// register. If the receiver stalls, the next result is held inside until the
// output register frees up, and no further request is taken meanwhile.
// Reset (synchronous, active low) empties the stack at once; record memory
// is not cleared since only slots below the fill level are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_unique_stack_core #(
  parameter int DEPTH = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  kus_in_if.sink   in_ch,
  kus_out_if.source out_ch
);

  kus_pkg::kus_cmd_t cmd;
  kus_pkg::kus_sts_t sts;

  // Controller: one request in flight, scan loop and result hand-off.
  kus_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: record RAM, depth and scan counters, result registers.
  kus_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_ch.action),
    .in_key         (in_ch.key),
    .in_payload     (in_ch.payload),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_key        (out_ch.out_key),
    .out_payload    (out_ch.out_payload),
    .out_is_empty   (out_ch.is_empty),
    .out_fill_count (out_ch.fill_count)
  );

endmodule

`default_nettype wire

// ===== src/kus_checker.sv =====
// ----------------------------------------------------------------------------
// kus_checker
// Port-level checks of the result channel, bound to the stack core.
// ----------------------------------------------------------------------------
`default_nettype none

module kus_checker #(
  parameter int DEPTH = 16
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [kus_pkg::STS_W-1:0]   out_status,
  input wire logic [kus_pkg::KEY_W-1:0]   out_key,
  input wire logic [kus_pkg::PAY_W-1:0]   out_payload,
  input wire logic                        out_is_empty,
  input wire logic [kus_pkg::FILL_W-1:0]  out_fill_count
);

  // A result that is not taken stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // A stalled result keeps its status, key, payload and fill count.
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_key)
      && $stable(out_payload) && $stable(out_fill_count))
    else $error("stalled result changed");

  // The empty flag agrees with the fill count (checked for depths below 32).
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (DEPTH < 32) |-> (out_is_empty == (out_fill_count == '0)))
    else $error("empty flag disagrees with fill count");

  // A full rejection reports a full stack and no record.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == kus_pkg::STS_FULL) |->
      (out_key == '0) && (out_payload == '0)
      && (out_fill_count == kus_pkg::FILL_W'(DEPTH)))
    else $error("full status with wrong contents");

  // Duplicate and miss results carry no record; a duplicate needs a record.
  a_no_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == kus_pkg::STS_DUP || out_status == kus_pkg::STS_MISS)
      |-> (out_key == '0) && (out_payload == '0)
        && !(out_status == kus_pkg::STS_DUP && out_is_empty))
    else $error("rejected result carries a record");

endmodule

bind keyed_unique_stack_core kus_checker #(
  .DEPTH (DEPTH)
) u_kus_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_key        (out_ch.out_key),
  .out_payload    (out_ch.out_payload),
  .out_is_empty   (out_ch.is_empty),
  .out_fill_count (out_ch.fill_count)
);

`default_nettype wire
